// ===== design/tpo_pkg.sv =====
package tpo_pkg;

    // delay line geometry
    localparam int DELAY_MAX = 8192;
    localparam int ADDR_W    = $clog2(DELAY_MAX);
    localparam int CNT_W     = $clog2(DELAY_MAX + 1);

    // field widths
    localparam int DLEN_W  = 14;
    localparam int SCALE_W = 10;
    localparam int GAIN_W  = 17;
    localparam int LIM_W   = 31;
    localparam int SIG_W   = 32;
    localparam int NRG_W   = 48;
    localparam int CFG_AW  = 2;
    localparam int CFG_DW  = 32;

    // memory word widths
    localparam int FWD_W  = SIG_W + SIG_W + NRG_W;
    localparam int BACK_W = SIG_W + SIG_W;

    // register indexes
    localparam logic [CFG_AW-1:0] REG_DELAY_LEN   = 2'd0;
    localparam logic [CFG_AW-1:0] REG_POS_SCALE   = 2'd1;
    localparam logic [CFG_AW-1:0] REG_SPRING_GAIN = 2'd2;
    localparam logic [CFG_AW-1:0] REG_FORCE_LIMIT = 2'd3;

    // reset values of the registers
    localparam logic [DLEN_W-1:0]  RST_DELAY_LEN   = 14'd500;
    localparam logic [SCALE_W-1:0] RST_POS_SCALE   = 10'd10;
    localparam logic [GAIN_W-1:0]  RST_SPRING_GAIN = 17'd655;
    localparam logic [LIM_W-1:0]   RST_FORCE_LIMIT = 31'd327680;

    // input kinds
    localparam logic KIND_TICK   = 1'b0;
    localparam logic KIND_REMOTE = 1'b1;

    // read tap of one circular line
    typedef struct packed {
        logic [ADDR_W-1:0] wr_addr;
        logic [ADDR_W-1:0] rd_addr;
        logic              rd_current;
        logic              rd_written;
    } t_tap_info;

    // q.32 fraction to q.16: add half, floor
    function automatic logic signed [49:0] f_round16(input logic signed [65:0] p);
        logic signed [65:0] t;
        t = p + 66'sd32768;
        return t[65:16];
    endfunction

    function automatic logic signed [31:0] f_sat32(input logic signed [50:0] v);
        if (v > 51'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -51'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [47:0] f_sat48(input logic signed [50:0] v);
        if (v > 51'sd140737488355327) begin
            return 48'sh7fffffffffff;
        end else if (v < -51'sd140737488355328) begin
            return 48'sh800000000000;
        end
        return v[47:0];
    endfunction

endpackage

// ===== design/tpo_if.sv =====
interface tpo_in_if
    import tpo_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             kind;
    logic [SIG_W-1:0] hand_position;
    logic [SIG_W-1:0] remote_velocity;
    logic [SIG_W-1:0] remote_force;

    modport source (output valid, kind, hand_position, remote_velocity, remote_force,
                    input ready);
    modport sink   (input valid, kind, hand_position, remote_velocity, remote_force,
                    output ready);
endinterface

interface tpo_out_if
    import tpo_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [SIG_W-1:0] force_command;
    logic [SIG_W-1:0] sent_position;
    logic [SIG_W-1:0] sent_spring_force;
    logic [NRG_W-1:0] sent_energy;
    logic [NRG_W-1:0] spring_energy;

    modport source (output valid, force_command, sent_position, sent_spring_force,
                    sent_energy, spring_energy, input ready);
    modport sink   (input valid, force_command, sent_position, sent_spring_force,
                    sent_energy, spring_energy, output ready);
endinterface

interface tpo_cfg_if
    import tpo_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CFG_AW-1:0] index;
    logic [CFG_DW-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/tpo_ram.sv =====
module tpo_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 8192,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/tpo_tap.sv =====
module tpo_tap
    import tpo_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [DLEN_W-1:0] i_delay_len,
    input  logic              i_push,
    output t_tap_info         o_info
);

    localparam logic [CNT_W:0] DMAX_X = (CNT_W + 1)'(DELAY_MAX);

    logic [ADDR_W-1:0] r_ptr, n_ptr;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic [ADDR_W-1:0] back_k;
    logic [CNT_W:0]    tap_sum;

    // distance back from the write slot, length clamped to 1..DELAY_MAX
    always_comb begin
        if (i_delay_len == '0) begin
            back_k = '0;
        end else if (int'(i_delay_len) > DELAY_MAX) begin
            back_k = ADDR_W'(DELAY_MAX - 1);
        end else begin
            back_k = ADDR_W'(i_delay_len - 1'b1);
        end
    end

    // circular tap address
    always_comb begin
        tap_sum = (CNT_W + 1)'(r_ptr) + DMAX_X - (CNT_W + 1)'(back_k);
        if (tap_sum >= DMAX_X) begin
            tap_sum = tap_sum - DMAX_X;
        end
    end

    assign o_info.wr_addr    = r_ptr;
    assign o_info.rd_addr    = tap_sum[ADDR_W-1:0];
    assign o_info.rd_current = (back_k == '0);
    assign o_info.rd_written = (r_fill >= CNT_W'(back_k));

    // pointer and fill count advance on a push
    always_comb begin
        n_ptr  = r_ptr;
        n_fill = r_fill;
        if (i_push) begin
            n_ptr = (int'(r_ptr) == DELAY_MAX - 1) ? '0 : r_ptr + 1'b1;
            if (int'(r_fill) < DELAY_MAX) begin
                n_fill = r_fill + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr  <= '0;
            r_fill <= '0;
        end else begin
            r_ptr  <= n_ptr;
            r_fill <= n_fill;
        end
    end

endmodule

// ===== design/teleop_master_force_passivity_observer.sv =====
// Master side of a delayed teleoperation link with two passivity observers.
// Channels: i_in takes beats of two kinds. A remote beat (kind 1) pushes a
// slave velocity and force sample into the backward delay line and updates
// the delayed velocity and force; it gives no result. A tick beat (kind 0)
// carries the hand position: the first tick after reset latches the origin
// and gives no result, every later tick gives one beat on o_res with the
// saturated force command, the delayed forward-line entry and the spring
// energy. i_cfg writes delay_len, position_scale, spring_gain, force_limit
// by index; it is always ready and is meant to be used while idle.
// Timing: one item is worked at a time. A remote beat runs states S_BRD and
// S_BWR, a first tick leaves the sequencer in S_IDLE, and a tick runs S_M1
// to S_M7 and loads its result into the output register as it leaves S_M7;
// this order comes from the read-then-write pass over the delay memories and
// from the single shared 33x33 multiplier that forms the products in turn.
// Stall: the result sits in an output register; if the receiver holds off
// while a previous result is still pending, the tick waits in its last
// step and input stays not ready.
// Reset: registers go to their reset values, all observers clear and the
// delay lines read as zero until written (fill count per line, no sweep).
module teleop_master_force_passivity_observer
    import tpo_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    tpo_in_if.sink      i_in,
    tpo_cfg_if.sink     i_cfg,
    tpo_out_if.source   o_res
);

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_BRD  = 10'b0000000010,
        S_BWR  = 10'b0000000100,
        S_M1   = 10'b0000001000,
        S_M2   = 10'b0000010000,
        S_M3   = 10'b0000100000,
        S_M4   = 10'b0001000000,
        S_M5   = 10'b0010000000,
        S_M6   = 10'b0100000000,
        S_M7   = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [DLEN_W-1:0]  r_delay_len;
    logic [SCALE_W-1:0] r_pos_scale;
    logic [GAIN_W-1:0]  r_spring_gain;
    logic [LIM_W-1:0]   r_force_limit;

    // architectural state
    logic               r_first;
    logic signed [31:0] r_origin, r_master, r_dvel, r_dfrc;
    logic signed [47:0] r_pos_nrg, r_spr_nrg;

    // working registers
    logic signed [31:0] r_hp, r_rvel, r_rfrc, r_x, r_scaled, r_fk;
    logic signed [65:0] r_prod;

    // output register
    logic               r_out_valid;
    logic [SIG_W-1:0]   r_force_cmd, r_sent_pos, r_sent_frc;
    logic [NRG_W-1:0]   r_sent_nrg, r_spr_out;

    // memories and taps
    t_tap_info          fwd_info, back_info;
    logic               fwd_push, back_push;
    logic [FWD_W-1:0]   fwd_q, fwd_wdata;
    logic [BACK_W-1:0]  back_q, back_wdata;

    logic               in_fire, out_free;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic signed [31:0] new_scaled, force_cmd;
    logic signed [32:0] fk_x, lim_x;
    logic signed [49:0] rnd;
    logic               prod_pos;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_res.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_len   <= RST_DELAY_LEN;
            r_pos_scale   <= RST_POS_SCALE;
            r_spring_gain <= RST_SPRING_GAIN;
            r_force_limit <= RST_FORCE_LIMIT;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_DELAY_LEN:   r_delay_len   <= i_cfg.data[DLEN_W-1:0];
                REG_POS_SCALE:   r_pos_scale   <= i_cfg.data[SCALE_W-1:0];
                REG_SPRING_GAIN: r_spring_gain <= i_cfg.data[GAIN_W-1:0];
                REG_FORCE_LIMIT: r_force_limit <= i_cfg.data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_in.kind == KIND_REMOTE) begin
                        n_state = S_BRD;
                    end else if (!r_first) begin
                        n_state = S_M1;
                    end
                end
            end
            S_BRD: n_state = S_BWR;
            S_BWR: n_state = S_IDLE;
            S_M1:  n_state = S_M2;
            S_M2:  n_state = S_M3;
            S_M3:  n_state = S_M4;
            S_M4:  n_state = S_M5;
            S_M5:  n_state = S_M6;
            S_M6:  n_state = S_M7;
            S_M7: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            S_M1: begin
                mul_a = 33'(r_master);
                mul_b = 33'(signed'({1'b0, r_pos_scale}));
            end
            S_M3: begin
                mul_a = 33'(r_scaled) - 33'(r_dvel);
                mul_b = 33'(signed'({1'b0, r_spring_gain}));
            end
            S_M4: begin
                mul_a = 33'(r_dfrc);
                mul_b = 33'(r_scaled);
            end
            S_M5: begin
                mul_a = 33'(r_fk);
                mul_b = 33'(r_dvel);
            end
            default: begin
                mul_a = 33'(r_x);
                mul_b = 33'(signed'({1'b0, r_pos_scale}));
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
    end

    assign rnd        = f_round16(r_prod);
    assign prod_pos   = !r_prod[65] && (r_prod != '0);
    assign new_scaled = f_sat32(r_prod[50:0]);

    // command clamp to the force limit
    always_comb begin
        fk_x  = 33'(r_fk);
        lim_x = 33'(signed'({2'b0, r_force_limit}));
        if (fk_x > lim_x) begin
            force_cmd = lim_x[31:0];
        end else if (fk_x < -lim_x) begin
            force_cmd = 32'(-lim_x);
        end else begin
            force_cmd = r_fk;
        end
    end

    // input capture and tick datapath
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_hp   <= i_in.hand_position;
            r_rvel <= i_in.remote_velocity;
            r_rfrc <= i_in.remote_force;
        end
        if (r_state == S_M1) begin
            r_x <= f_sat32(51'(r_hp) - 51'(r_origin));
        end
        if (r_state == S_M2) begin
            r_scaled <= f_sat32(r_prod[50:0]);
        end
        if (r_state == S_M4) begin
            r_fk <= f_sat32(-51'(rnd));
        end
    end

    // observers and model state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first   <= 1'b1;
            r_origin  <= '0;
            r_master  <= '0;
            r_dvel    <= '0;
            r_dfrc    <= '0;
            r_pos_nrg <= '0;
            r_spr_nrg <= '0;
        end else begin
            if (in_fire && i_in.kind == KIND_TICK && r_first) begin
                r_origin <= i_in.hand_position;
                r_first  <= 1'b0;
            end
            if (r_state == S_BWR) begin
                if (back_info.rd_current) begin
                    r_dvel <= r_rvel;
                    r_dfrc <= r_rfrc;
                end else if (back_info.rd_written) begin
                    r_dvel <= back_q[BACK_W-1:SIG_W];
                    r_dfrc <= back_q[SIG_W-1:0];
                end else begin
                    r_dvel <= '0;
                    r_dfrc <= '0;
                end
            end
            if (r_state == S_M5 && prod_pos) begin
                r_pos_nrg <= f_sat48(51'(r_pos_nrg) + 51'(rnd));
            end
            if (r_state == S_M6 && prod_pos) begin
                r_spr_nrg <= f_sat48(51'(r_spr_nrg) - 51'(rnd));
            end
            if (r_state == S_M7 && out_free) begin
                r_master <= r_x;
            end
        end
    end

    // backward line: velocity and force
    assign back_push  = (r_state == S_BWR);
    assign back_wdata = {r_rvel, r_rfrc};

    tpo_tap u_back_tap (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_delay_len (r_delay_len),
        .i_push      (back_push),
        .o_info      (back_info)
    );

    tpo_ram #(
        .WIDTH (BACK_W),
        .DEPTH (DELAY_MAX)
    ) u_back_ram (
        .i_clk     (i_clk),
        .i_we      (back_push),
        .i_wr_addr (back_info.wr_addr),
        .i_wr_data (back_wdata),
        .i_re      (r_state == S_BRD),
        .i_rd_addr (back_info.rd_addr),
        .o_rd_data (back_q)
    );

    // forward line: scaled position, spring force, position energy
    assign fwd_push  = (r_state == S_M7) && out_free;
    assign fwd_wdata = {new_scaled, r_fk, r_pos_nrg};

    tpo_tap u_fwd_tap (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_delay_len (r_delay_len),
        .i_push      (fwd_push),
        .o_info      (fwd_info)
    );

    tpo_ram #(
        .WIDTH (FWD_W),
        .DEPTH (DELAY_MAX)
    ) u_fwd_ram (
        .i_clk     (i_clk),
        .i_we      (fwd_push),
        .i_wr_addr (fwd_info.wr_addr),
        .i_wr_data (fwd_wdata),
        .i_re      (r_state == S_M6),
        .i_rd_addr (fwd_info.rd_addr),
        .o_rd_data (fwd_q)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fwd_push) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fwd_push) begin
            r_force_cmd <= force_cmd;
            r_spr_out   <= r_spr_nrg;
            if (fwd_info.rd_current) begin
                r_sent_pos <= new_scaled;
                r_sent_frc <= r_fk;
                r_sent_nrg <= r_pos_nrg;
            end else if (fwd_info.rd_written) begin
                r_sent_pos <= fwd_q[FWD_W-1 -: SIG_W];
                r_sent_frc <= fwd_q[NRG_W +: SIG_W];
                r_sent_nrg <= fwd_q[NRG_W-1:0];
            end else begin
                r_sent_pos <= '0;
                r_sent_frc <= '0;
                r_sent_nrg <= '0;
            end
        end
    end

    assign o_res.valid             = r_out_valid;
    assign o_res.force_command     = r_force_cmd;
    assign o_res.sent_position     = r_sent_pos;
    assign o_res.sent_spring_force = r_sent_frc;
    assign o_res.sent_energy       = r_sent_nrg;
    assign o_res.spring_energy     = r_spr_out;

endmodule
